// ===== rtl/tcss_pkg.sv =====
// Shared types, constants and helper functions of the ticket counter block.
package tcss_pkg;

    localparam int DIGITS  = 4;
    localparam int POS_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int MSG_LEN = DIGITS + 2;
    localparam int IDX_W   = $clog2(MSG_LEN);
    localparam int CFG_IDX_W = 2;

    typedef logic [3:0] bcd_t;
    typedef bcd_t [DIGITS-1:0] digits_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [IDX_W-1:0] msg_idx_t;

    typedef struct packed {
        logic inc;
        logic scan_adv;
    } cnt_ctrl_t;

    localparam logic [1:0] ACT_SERIAL = 2'd0;
    localparam logic [1:0] ACT_BUTTON = 2'd1;
    localparam logic [1:0] ACT_SCAN   = 2'd2;

    localparam logic KIND_DISPLAY = 1'b0;
    localparam logic KIND_TX      = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_REQ_ONE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_TWO = CFG_IDX_W'(1);

    localparam logic [7:0] REQ_ONE_RESET = 8'h26;
    localparam logic [7:0] REQ_TWO_RESET = 8'h40;
    localparam logic [7:0] CHAR_BANG     = 8'h21;
    localparam logic [7:0] CHAR_DOT      = 8'h2E;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
    localparam logic [7:0] SEL_OFF       = 8'hFF;

    localparam pos_t     LAST_POS = pos_t'(DIGITS - 1);
    localparam msg_idx_t LAST_IDX = msg_idx_t'(MSG_LEN - 1);

    // Common-anode, active-low segment patterns for 0 to 9; other codes blank.
    function automatic logic [7:0] seg_pattern(input bcd_t d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] digit_sel(input pos_t p);
        logic [7:0] m;
        m = 8'h80 >> p;
        return ~m;
    endfunction

    // Decimal increment, least significant digit in the highest index.
    function automatic digits_t bcd_inc(input digits_t d);
        digits_t r;
        logic    carry;
        r     = d;
        carry = 1'b1;
        for (int i = DIGITS - 1; i >= 0; i--)
        begin
            if (carry)
            begin
                if (d[i] >= 4'd9)
                begin
                    r[i] = 4'd0;
                end
                else
                begin
                    r[i]  = d[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/tcss_counter.sv =====
// BCD ticket count and display scan position registers.
module tcss_counter (
    input  logic                clk,
    input  logic                rst_n,
    input  tcss_pkg::cnt_ctrl_t ctrl,
    output tcss_pkg::digits_t   digits,
    output tcss_pkg::digits_t   digits_inc,
    output tcss_pkg::pos_t      scan_pos
);
    import tcss_pkg::*;

    digits_t count_reg;
    digits_t count_next;
    pos_t    pos_reg;
    pos_t    pos_next;

    always_comb
    begin
        digits_inc = bcd_inc(count_reg);
        count_next = ctrl.inc ? digits_inc : count_reg;
        pos_next   = pos_reg;
        if (ctrl.scan_adv)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + pos_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    assign digits   = count_reg;
    assign scan_pos = pos_reg;

endmodule

// ===== rtl/ticket_counter_seven_segment_top.sv =====
// Top level of the ticket counter with multiplexed seven-segment display output.
// An accepted item waits in the input register and its result is registered in the output register.
// Serial items are taken one per cycle and scan items one per cycle while the output is not
// stalled; a button item sends DIGITS + 2 message bytes, one per cycle while the output is not
// stalled, and keeps the block busy while the next item waits in the input register.
// Reset clears the count to zero, points the scan at the thousands digit, restores the
// request characters to '&' and '@', and empties the input and output registers.
module ticket_counter_seven_segment_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       action,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             kind,
    output logic [7:0]                       segments,
    output logic [7:0]                       digit_select,
    output logic [7:0]                       tx_byte,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                       cfg_data
);
    import tcss_pkg::*;

    // Configuration registers
    logic [7:0] req_one_reg;
    logic [7:0] req_two_reg;

    // Input register
    logic       in_v_reg;
    logic       in_v_next;
    logic [1:0] act_reg;
    logic [7:0] rx_reg;
    logic       in_load;

    // Message sequencer
    logic     gen_busy_reg;
    logic     gen_busy_next;
    msg_idx_t gen_idx_reg;
    msg_idx_t gen_idx_next;
    digits_t  msg_reg;
    digits_t  msg_next;

    // Output register
    logic       out_v_reg;
    logic       out_v_next;
    logic       kind_reg;
    logic [7:0] seg_reg;
    logic [7:0] sel_reg;
    logic [7:0] tx_reg;
    logic       last_reg;

    // Result of this cycle
    logic       res_valid;
    logic       res_kind;
    logic [7:0] res_seg;
    logic [7:0] res_sel;
    logic [7:0] res_tx;
    logic       res_last;

    logic       out_load;
    logic       need_out;
    logic       proc;
    logic       gen_emit;
    logic       gen_is_last;
    logic       match;

    cnt_ctrl_t  ctrl;
    digits_t    digits;
    digits_t    digits_inc;
    pos_t       scan_pos;

    tcss_counter u_counter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .digits     (digits),
        .digits_inc (digits_inc),
        .scan_pos   (scan_pos)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_one_reg <= REQ_ONE_RESET;
            req_two_reg <= REQ_TWO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_REQ_ONE: req_one_reg <= cfg_data;
                CFG_REQ_TWO: req_two_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign out_load    = !out_v_reg || !out_stall;
    assign need_out    = (act_reg == ACT_BUTTON) || (act_reg == ACT_SCAN);
    assign proc        = in_v_reg && !gen_busy_reg && (!need_out || out_load);
    assign gen_emit    = gen_busy_reg && out_load;
    assign gen_is_last = (gen_idx_reg == LAST_IDX);
    assign match       = (rx_reg == req_one_reg) || (rx_reg == req_two_reg);

    assign in_stall = in_v_reg && !proc;
    assign in_load  = in_valid && !in_stall;

    always_comb
    begin
        ctrl          = '0;
        res_valid     = 1'b0;
        res_kind      = KIND_TX;
        res_seg       = SEL_OFF;
        res_sel       = SEL_OFF;
        res_tx        = 8'h00;
        res_last      = 1'b0;
        gen_busy_next = gen_busy_reg;
        gen_idx_next  = gen_idx_reg;
        msg_next      = msg_reg;

        if (gen_emit)
        begin
            // Digits leave from the front of the snapshot, which shifts by one each byte.
            res_valid = 1'b1;
            res_last  = gen_is_last;
            res_tx    = gen_is_last ? CHAR_DOT : {ASCII_DIGIT_HI, msg_reg[0]};
            for (int i = 0; i < DIGITS - 1; i++)
            begin
                msg_next[i] = msg_reg[i+1];
            end
            gen_idx_next  = gen_idx_reg + msg_idx_t'(1);
            gen_busy_next = !gen_is_last;
        end

        if (proc)
        begin
            case (act_reg)
                ACT_SERIAL:
                begin
                    ctrl.inc = match;
                end
                ACT_BUTTON:
                begin
                    ctrl.inc      = 1'b1;
                    res_valid     = 1'b1;
                    res_tx        = CHAR_BANG;
                    gen_busy_next = 1'b1;
                    gen_idx_next  = msg_idx_t'(1);
                    msg_next      = digits_inc;
                end
                ACT_SCAN:
                begin
                    ctrl.scan_adv = 1'b1;
                    res_valid     = 1'b1;
                    res_kind      = KIND_DISPLAY;
                    res_seg       = seg_pattern(digits[scan_pos]);
                    res_sel       = digit_sel(scan_pos);
                    res_last      = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        in_v_next = in_v_reg;
        if (in_load)
        begin
            in_v_next = 1'b1;
        end
        else if (proc)
        begin
            in_v_next = 1'b0;
        end
        out_v_next = out_load ? res_valid : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg     <= 1'b0;
            gen_busy_reg <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            in_v_reg     <= in_v_next;
            gen_busy_reg <= gen_busy_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            act_reg <= action;
            rx_reg  <= rx_byte;
        end
        gen_idx_reg <= gen_idx_next;
        msg_reg     <= msg_next;
        if (out_load && res_valid)
        begin
            kind_reg <= res_kind;
            seg_reg  <= res_seg;
            sel_reg  <= res_sel;
            tx_reg   <= res_tx;
            last_reg <= res_last;
        end
    end

    assign out_valid    = out_v_reg;
    assign kind         = kind_reg;
    assign segments     = seg_reg;
    assign digit_select = sel_reg;
    assign tx_byte      = tx_reg;
    assign last         = last_reg;

endmodule

// ===== verif/ticket_counter_seven_segment_top_tb.sv =====
// Self-checking testbench for the ticket counter with multiplexed seven-segment output.
module ticket_counter_seven_segment_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcss_pkg::*;

    localparam int LIMIT = 2000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
    // Segment codes for the decimal digits, index 0 in the lowest byte.
    localparam logic [9:0][7:0] SEG_CODE = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                            8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

    typedef struct packed {
        logic       kind;
        logic [7:0] seg;
        logic [7:0] sel;
        logic [7:0] tx;
        logic       last;
    } drive_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           action;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic                 kind;
    logic [7:0]           segments;
    logic [7:0]           digit_select;
    logic [7:0]           tx_byte;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // Mirror of the block: the BCD count (most significant digit first),
    // the scan position and the two request characters.
    bcd_t       tally [DIGITS];
    int         scan_at;
    logic [7:0] req_one;
    logic [7:0] req_two;

    drive_t owed_outputs [$];
    drive_t got_out;
    drive_t want_out;
    int     faults;
    int     quiet_cycles;
    int     send_gap_pct;
    int     stall_pct;

    ticket_counter_seven_segment_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .segments     (segments),
        .digit_select (digit_select),
        .tx_byte      (tx_byte),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void bump_tally();
        logic carry;
        carry = 1'b1;
        for (int i = DIGITS - 1; i >= 0; i--)
        begin
            if (carry)
            begin
                if (tally[i] >= 4'd9)
                begin
                    tally[i] = 4'd0;
                end
                else
                begin
                    tally[i] = tally[i] + 4'd1;
                    carry    = 1'b0;
                end
            end
        end
    endfunction

    function automatic void count_and_emit(input logic [1:0] act, input logic [7:0] rx);
        case (act)
            ACT_SERIAL:
            begin
                if (rx == req_one || rx == req_two)
                begin
                    bump_tally();
                end
            end
            ACT_BUTTON:
            begin
                bump_tally();
                owed_outputs.push_back({KIND_TX, SEL_OFF, SEL_OFF, CHAR_BANG, 1'b0});
                for (int i = 0; i < DIGITS; i++)
                begin
                    owed_outputs.push_back({KIND_TX, SEL_OFF, SEL_OFF,
                                            {ASCII_DIGIT_HI, tally[i]}, 1'b0});
                end
                owed_outputs.push_back({KIND_TX, SEL_OFF, SEL_OFF, CHAR_DOT, 1'b1});
            end
            ACT_SCAN:
            begin
                owed_outputs.push_back({KIND_DISPLAY, SEG_CODE[tally[scan_at]],
                                        ~(8'h80 >> scan_at), 8'h00, 1'b1});
                scan_at = (scan_at == DIGITS - 1) ? 0 : scan_at + 1;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_event(input logic [1:0] act, input logic [7:0] rx);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        rx_byte  <= rx;
        do
            @(posedge clk);
        while (in_stall);
        count_and_emit(act, rx);
    endtask

    // Drains the block so that the request characters may be changed safely.
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_REQ_ONE)
        begin
            req_one = val;
        end
        else if (idx == CFG_REQ_TWO)
        begin
            req_two = val;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        // Five scans show all zeros and wrap back to the thousands digit.
        repeat (5) send_event(ACT_SCAN, 8'h00);
        send_event(ACT_UNUSED, REQ_ONE_RESET);
        send_event(ACT_UNUSED, 8'hFF);
        send_event(ACT_SERIAL, 8'h00);
        send_event(ACT_SERIAL, 8'hFF);
        send_event(ACT_SCAN, 8'hFF);
    endtask

    task automatic test_default_requests();
        send_event(ACT_SERIAL, REQ_ONE_RESET);
        send_event(ACT_SERIAL, REQ_TWO_RESET);
        send_event(ACT_BUTTON, 8'h00);
        repeat (3) send_event(ACT_SCAN, 8'h00);
    endtask

    task automatic test_register_writes();
        settle_idle();
        write_reg(CFG_REQ_ONE, 8'h00);
        write_reg(CFG_REQ_TWO, 8'hFF);
        send_event(ACT_SERIAL, REQ_ONE_RESET);
        send_event(ACT_SERIAL, 8'h00);
        send_event(ACT_SERIAL, 8'hFF);
        send_event(ACT_BUTTON, 8'hFF);
        settle_idle();
        // Writes to the spare indexes must leave both characters alone.
        write_reg(CFG_SPARE_A, 8'hAA);
        write_reg(CFG_SPARE_B, 8'h55);
        send_event(ACT_SERIAL, 8'hAA);
        send_event(ACT_SERIAL, 8'h55);
        send_event(ACT_BUTTON, 8'h00);
        settle_idle();
        // With both characters equal a match still counts only once.
        write_reg(CFG_REQ_ONE, 8'h5A);
        write_reg(CFG_REQ_TWO, 8'h5A);
        send_event(ACT_SERIAL, 8'h5A);
        send_event(ACT_BUTTON, 8'h00);
    endtask

    task automatic test_count_wrap();
        int v;
        do
        begin
            v = 0;
            for (int i = 0; i < DIGITS; i++)
            begin
                v = v * 10 + tally[i];
            end
            if (v != (10 ** DIGITS) - 2)
            begin
                send_event(ACT_SERIAL, req_one);
            end
        end
        while (v != (10 ** DIGITS) - 2);
        send_event(ACT_BUTTON, 8'h00);
        repeat (DIGITS) send_event(ACT_SCAN, 8'h00);
        send_event(ACT_BUTTON, 8'h00);
        send_event(ACT_SCAN, 8'h00);
    endtask

    task automatic test_random(input int n);
        int         made;
        int         pick;
        logic [1:0] act;
        logic [7:0] rx;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(99);
            rx   = 8'($urandom_range(255));
            if (pick < 30)
            begin
                act = ACT_SERIAL;
                if (pick >= 12)
                begin
                    rx = pick[0] ? req_one : req_two;
                end
            end
            else if (pick < 55)
            begin
                act = ACT_BUTTON;
            end
            else if (pick < 90)
            begin
                act = ACT_SCAN;
            end
            else
            begin
                act = ACT_UNUSED;
            end
            if (act == ACT_BUTTON || act == ACT_SCAN ||
                (act == ACT_SERIAL && (rx == req_one || rx == req_two)))
            begin
                made++;
            end
            send_event(act, rx);
        end
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_out = {kind, segments, digit_select, tx_byte, last};
            if (owed_outputs.size() == 0)
            begin
                faults++;
                $display("%0t: unexpected result, expected none, actual ", $time,
                         "kind %0d seg %h sel %h tx %h last %0d",
                         got_out.kind, got_out.seg, got_out.sel, got_out.tx, got_out.last);
            end
            else
            begin
                want_out = owed_outputs.pop_front();
                if (got_out !== want_out)
                begin
                    faults++;
                    $display("%0t: mismatch, expected kind %0d seg %h sel %h tx %h last %0d,",
                             $time, want_out.kind, want_out.seg, want_out.sel,
                             want_out.tx, want_out.last,
                             " actual kind %0d seg %h sel %h tx %h last %0d",
                             got_out.kind, got_out.seg, got_out.sel, got_out.tx, got_out.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_SERIAL;
        rx_byte      = 8'h00;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_REQ_ONE;
        cfg_data     = 8'h00;
        faults       = 0;
        quiet_cycles = 0;
        scan_at      = 0;
        req_one      = REQ_ONE_RESET;
        req_two      = REQ_TWO_RESET;
        for (int i = 0; i < DIGITS; i++)
        begin
            tally[i] = 4'd0;
        end
        send_gap_pct = 11;
        stall_pct    = 69;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_default_requests();
        test_register_writes();
        test_count_wrap();

        settle_idle();
        write_reg(CFG_REQ_ONE, 8'($urandom_range(255)));
        write_reg(CFG_REQ_TWO, 8'($urandom_range(255)));
        test_random(100);

        settle_idle();
        send_gap_pct = 69;
        stall_pct    = 11;
        write_reg(CFG_REQ_ONE, 8'($urandom_range(255)));
        write_reg(CFG_REQ_TWO, 8'($urandom_range(255)));
        test_random(100);

        settle_idle();
        send_gap_pct = 0;
        stall_pct    = 0;
        write_reg(CFG_REQ_ONE, 8'hFF);
        write_reg(CFG_REQ_TWO, 8'h00);
        test_random(100);

        settle_idle();
        if (faults == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== ticket_counter_seven_segment_top.f =====
rtl/tcss_pkg.sv
rtl/tcss_counter.sv
rtl/ticket_counter_seven_segment_top.sv
verif/ticket_counter_seven_segment_top_tb.sv
